// ===== hdl/hsv2rgb_pkg.sv =====
// types and helpers shared by the hsv to rgb converter
// no dependencies
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CHAN_W = 8;

  localparam logic [HUE_W-1:0]  FULL_TURN   = 9'd360;
  localparam logic [HUE_W-1:0]  SECTOR_DEG  = 9'd60;
  localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

  // hue sector codes, 60 degrees each
  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;
  localparam logic [2:0] SEC_MAGENTA = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_degrees;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // round(x / 255) for x up to 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] y;
    logic [2*CHAN_W:0] z;
    y = {1'b0, x} + 17'd127;
    z = y + {8'd0, y[2*CHAN_W:CHAN_W]} + 17'd1;
    return z[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// ===== hdl/hsv_to_rgb_converter.sv =====
// hsv to rgb converter, five register stages
// depends on hsv2rgb_pkg
`timescale 1ns / 1ps

// Converts one hsv color per transfer into one rgb color.
// Input channel: in_valid / in_stall / in_data (hue in degrees, saturation
// and brightness as 8-bit fractions, 255 = 1.0). Output channel: out_valid /
// out_stall / out_data (red, green, blue, 255 = 1.0).
// Each input transfer passes through the stage registers in order and leaves
// from the output register, where out_valid marks it.
// Throughput is one color per clock while out_stall is low; each stage holds
// one item and a stage moves on when the stage after it is empty or moving, so bubbles close up.
// Stages: hue wrap and sector split, three 8x8 products, rounding divide
// by 255, two more products, final divide and channel select into the
// output register.
// Reset (rst, synchronous) empties every stage; out_valid falls.
// While out_stall is high the output holds its data; the stages behind it
// keep filling, and in_stall rises once the first stage is full and blocked.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  hsv_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rgb_t out_data
);

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5 || !out_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign in_stall  = !adv1;
  assign out_valid = v5;

  // stage 1: wrap, sector, fraction
  logic [HUE_W-1:0]  hue_w;
  logic [2:0]        sec_c;
  logic [HUE_W-1:0]  sec_base;
  logic [HUE_W-1:0]  rem_full;
  logic [5:0]        rem_c;
  logic [CHAN_W+3:0] f_scaled;

  always_comb begin
    hue_w = (in_data.hue_degrees >= FULL_TURN) ? in_data.hue_degrees - FULL_TURN
                                               : in_data.hue_degrees;
    priority if (hue_w >= 5 * SECTOR_DEG) begin
      sec_c = SEC_MAGENTA;
    end else if (hue_w >= 4 * SECTOR_DEG) begin
      sec_c = SEC_BLUE;
    end else if (hue_w >= 3 * SECTOR_DEG) begin
      sec_c = SEC_CYAN;
    end else if (hue_w >= 2 * SECTOR_DEG) begin
      sec_c = SEC_GREEN;
    end else if (hue_w >= SECTOR_DEG) begin
      sec_c = SEC_YELLOW;
    end else begin
      sec_c = SEC_RED;
    end
    sec_base = HUE_W'(sec_c * SECTOR_DEG);
    rem_full = hue_w - sec_base;
    rem_c    = rem_full[5:0];
    // (rem * 255 + 30) / 60 reduces to (rem * 17 + 2) / 4
    f_scaled = 12'(rem_c) * 12'd17 + 12'd2;
  end

  logic [2:0]        s1_sec;
  logic [CHAN_W-1:0] s1_f, s1_s, s1_v;
  logic              s1_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      s1_sec  <= sec_c;
      s1_f    <= f_scaled[CHAN_W+1:2];
      s1_s    <= in_data.saturation;
      s1_v    <= in_data.brightness;
      s1_gray <= (in_data.saturation == '0);
    end
  end

  // stage 2: products s*f, s*(1-f), v*(1-s)
  logic [2:0]          s2_sec;
  logic [CHAN_W-1:0]   s2_v;
  logic                s2_gray;
  logic [2*CHAN_W-1:0] s2_sf, s2_sfn, s2_vs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      s2_sec  <= s1_sec;
      s2_v    <= s1_v;
      s2_gray <= s1_gray;
      s2_sf   <= s1_s * s1_f;
      s2_sfn  <= s1_s * (CHAN_MAX - s1_f);
      s2_vs   <= s1_v * (CHAN_MAX - s1_s);
    end
  end

  // stage 3: rescale the three products
  logic [2:0]        s3_sec;
  logic [CHAN_W-1:0] s3_v, s3_p, s3_sf, s3_sfn;
  logic              s3_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      s3_sec  <= s2_sec;
      s3_v    <= s2_v;
      s3_gray <= s2_gray;
      s3_p    <= div255(s2_vs);
      s3_sf   <= div255(s2_sf);
      s3_sfn  <= div255(s2_sfn);
    end
  end

  // stage 4: v*(1-s*f) and v*(1-s*(1-f))
  logic [2:0]          s4_sec;
  logic [CHAN_W-1:0]   s4_v, s4_p;
  logic                s4_gray;
  logic [2*CHAN_W-1:0] s4_qm, s4_tm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3;
    end
    if (adv4) begin
      s4_sec  <= s3_sec;
      s4_v    <= s3_v;
      s4_p    <= s3_p;
      s4_gray <= s3_gray;
      s4_qm   <= s3_v * (CHAN_MAX - s3_sf);
      s4_tm   <= s3_v * (CHAN_MAX - s3_sfn);
    end
  end

  // stage 5: final rescale and channel select
  logic [CHAN_W-1:0] q_c, t_c;
  rgb_t              rgb_next;

  always_comb begin
    q_c = div255(s4_qm);
    t_c = div255(s4_tm);
    if (s4_gray) begin
      rgb_next = '{red: s4_v, green: s4_v, blue: s4_v};
    end else begin
      unique case (s4_sec)
        SEC_RED:    rgb_next = '{red: s4_v, green: t_c,  blue: s4_p};
        SEC_YELLOW: rgb_next = '{red: q_c,  green: s4_v, blue: s4_p};
        SEC_GREEN:  rgb_next = '{red: s4_p, green: s4_v, blue: t_c};
        SEC_CYAN:   rgb_next = '{red: s4_p, green: q_c,  blue: s4_v};
        SEC_BLUE:   rgb_next = '{red: t_c,  green: s4_p, blue: s4_v};
        default:    rgb_next = '{red: s4_v, green: s4_p, blue: q_c};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv5) begin
      v5 <= v4;
    end
    if (adv5) begin
      out_data <= rgb_next;
    end
  end

endmodule
